@@ src/bctp_pkg.sv @@
// Shared types and constants for the block-cyclic transfer planner.
package bctp_pkg;

  localparam int unsigned MAX_GRID_DIM  = 16;
  localparam int unsigned MAX_SHARD_DIM = 65535;

  localparam int unsigned GridW    = 5;
  localparam int unsigned DimW     = 16;
  localparam int unsigned IdxW     = 20;
  localparam int unsigned RankW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Source process row/col: global offset is below shard * grid, so the
  // quotient is below the grid dimension.
  localparam int unsigned SpQW  = $clog2(MAX_GRID_DIM);
  // Tile index over grid dimension stays below shard / tile.
  localparam int unsigned TqQW  = DimW;
  // Shard remainder of shard / tile size.
  localparam int unsigned ModQW = DimW;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GRID_ROWS   = 3'd0,
    REG_GRID_COLS   = 3'd1,
    REG_TILE_HEIGHT = 3'd2,
    REG_TILE_WIDTH  = 3'd3,
    REG_SHARD_ROWS  = 3'd4,
    REG_SHARD_COLS  = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_BAD_SIZE    = 3'd1,
    STATUS_UNALIGNED   = 3'd2,
    STATUS_RECT_OOB    = 3'd3,
    STATUS_TILE_RANGE  = 3'd4
  } status_e;

  typedef enum logic {
    PHASE_COL = 1'b0,
    PHASE_ROW = 1'b1
  } phase_e;

  typedef struct packed {
    logic [IdxW-1:0] tile_row_index;
    logic [IdxW-1:0] tile_col_index;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    phase_e           phase_id;
    logic [RankW-1:0] from_rank;
    logic [RankW-1:0] to_rank;
    logic [DimW-1:0]  src_row_offset;
    logic [DimW-1:0]  src_col_offset;
    logic [DimW-1:0]  dst_row_offset;
    logic [DimW-1:0]  dst_col_offset;
    logic             last_of_tile;
  } out_item_t;

endpackage

@@ src/bctp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, constant divisor.
module bctp_div #(
  parameter int unsigned NW = 20,
  parameter int unsigned DW = 5,
  parameter int unsigned QW = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic [QW-1:0] quot_o,
  output logic [NW-1:0] rem_o
);

  localparam int unsigned XW = NW + QW;

  logic [NW-1:0] rem_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_step
    localparam int unsigned Bit = QW - 1 - s;
    logic [NW-1:0] rem_in, rem_d;
    logic [QW-1:0] quo_in, quo_d;
    logic [XW-1:0] rem_x, dsh;

    if (s == 0) begin : g_first
      assign rem_in = dividend_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    always_comb begin
      rem_x = XW'(rem_in);
      dsh   = XW'(divisor_i) << Bit;
      rem_d = rem_in;
      quo_d = quo_in;
      if (rem_x >= dsh) begin
        rem_d      = NW'(rem_x - dsh);
        quo_d[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        quo_q[s] <= quo_d;
      end
    end
  end

  assign quot_o = quo_q[QW-1];
  assign rem_o  = rem_q[QW-1];

endmodule

@@ src/block_cyclic_transfer_planner_core.sv @@
// Top level of the block-cyclic transfer planner pipeline.
// Throughput: one tile per cycle while the output is not stalled; a tile that needs
//   both phases stalls the input while its second descriptor waits in the pending register.
// Reset: registers return to 1, the pipeline and output register empty.
module block_cyclic_transfer_planner_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  bctp_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output bctp_pkg::out_item_t                out_data_o,
  input  logic                               cfg_we_i,
  input  logic [bctp_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [bctp_pkg::CfgDataW-1:0]      cfg_wdata_i
);

  localparam int unsigned GridW = bctp_pkg::GridW;
  localparam int unsigned DimW  = bctp_pkg::DimW;
  localparam int unsigned IdxW  = bctp_pkg::IdxW;
  localparam int unsigned RankW = bctp_pkg::RankW;
  localparam int unsigned SpQW  = bctp_pkg::SpQW;
  localparam int unsigned TqQW  = bctp_pkg::TqQW;
  localparam int unsigned ModQW = bctp_pkg::ModQW;
  localparam int unsigned GrowW = IdxW + DimW;
  localparam int unsigned NrW   = IdxW + 1 + DimW;
  localparam int unsigned LimW  = DimW + GridW;
  localparam int unsigned StSp  = 2 + SpQW;   // source row/col divider output
  localparam int unsigned StDv  = 1 + TqQW;   // long divider output
  localparam int unsigned StL   = StDv + 1;   // last pipeline stage

  // configuration
  logic [GridW-1:0] grid_rows_q, grid_cols_q;
  logic [DimW-1:0]  tile_height_q, tile_width_q, shard_rows_q, shard_cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q   <= GridW'(1);
      grid_cols_q   <= GridW'(1);
      tile_height_q <= DimW'(1);
      tile_width_q  <= DimW'(1);
      shard_rows_q  <= DimW'(1);
      shard_cols_q  <= DimW'(1);
    end else if (cfg_we_i) begin
      case (bctp_pkg::reg_idx_e'(cfg_idx_i))
        bctp_pkg::REG_GRID_ROWS:   grid_rows_q   <= cfg_wdata_i[GridW-1:0];
        bctp_pkg::REG_GRID_COLS:   grid_cols_q   <= cfg_wdata_i[GridW-1:0];
        bctp_pkg::REG_TILE_HEIGHT: tile_height_q <= cfg_wdata_i[DimW-1:0];
        bctp_pkg::REG_TILE_WIDTH:  tile_width_q  <= cfg_wdata_i[DimW-1:0];
        bctp_pkg::REG_SHARD_ROWS:  shard_rows_q  <= cfg_wdata_i[DimW-1:0];
        bctp_pkg::REG_SHARD_COLS:  shard_cols_q  <= cfg_wdata_i[DimW-1:0];
        default: ;
      endcase
    end
  end

  // flow control: whole pipeline moves together
  logic adv;
  logic out_valid_q, pend_valid_q;
  bctp_pkg::out_item_t out_q, pend_q;
  logic [StL:1] v_q;

  assign adv        = !out_valid_q || (!out_stall_i && !pend_valid_q);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[StL-1:1], in_valid_i};
    end
  end

  // stage 1: input
  logic [IdxW-1:0] tr1_q, tc1_q;

  // stage 2: products
  logic [IdxW-1:0] grow2_q, gcol2_q;
  logic [NrW-1:0]  nr2_q, nc2_q;
  logic [LimW-1:0] limr2_q, limc2_q;
  logic [GrowW-1:0] grow_full, gcol_full;
  logic [NrW-1:0]  nr_d, nc_d;
  logic [LimW-1:0] limr_d, limc_d;

  always_comb begin
    grow_full = GrowW'(tr1_q) * GrowW'(tile_height_q);
    gcol_full = GrowW'(tc1_q) * GrowW'(tile_width_q);
    nr_d      = (NrW'(tr1_q) + NrW'(1)) * NrW'(tile_height_q);
    nc_d      = (NrW'(tc1_q) + NrW'(1)) * NrW'(tile_width_q);
    limr_d    = LimW'(shard_rows_q) * LimW'(grid_rows_q);
    limc_d    = LimW'(shard_cols_q) * LimW'(grid_cols_q);
  end

  // tile index out of range: (t + 1) * tile > shard * grid
  logic oor_d;
  assign oor_d = (nr2_q > NrW'(limr2_q)) || (nc2_q > NrW'(limc2_q));

  // dividers
  logic [TqQW-1:0]  qr_quo, qc_quo;
  logic [IdxW-1:0]  qr_rem, qc_rem;
  logic [ModQW-1:0] mr_quo, mc_quo;
  logic [DimW-1:0]  mr_rem, mc_rem;
  logic [SpQW-1:0]  sp_quo, spc_quo;
  logic [IdxW-1:0]  sp_rem, spc_rem;

  bctp_div #(.NW(IdxW), .DW(GridW), .QW(TqQW)) u_div_tr (
    .clk_i, .en_i(adv), .dividend_i(tr1_q), .divisor_i(grid_rows_q),
    .quot_o(qr_quo), .rem_o(qr_rem)
  );
  bctp_div #(.NW(IdxW), .DW(GridW), .QW(TqQW)) u_div_tc (
    .clk_i, .en_i(adv), .dividend_i(tc1_q), .divisor_i(grid_cols_q),
    .quot_o(qc_quo), .rem_o(qc_rem)
  );
  bctp_div #(.NW(DimW), .DW(DimW), .QW(ModQW)) u_mod_r (
    .clk_i, .en_i(adv), .dividend_i(shard_rows_q), .divisor_i(tile_height_q),
    .quot_o(mr_quo), .rem_o(mr_rem)
  );
  bctp_div #(.NW(DimW), .DW(DimW), .QW(ModQW)) u_mod_c (
    .clk_i, .en_i(adv), .dividend_i(shard_cols_q), .divisor_i(tile_width_q),
    .quot_o(mc_quo), .rem_o(mc_rem)
  );
  bctp_div #(.NW(IdxW), .DW(DimW), .QW(SpQW)) u_div_sr (
    .clk_i, .en_i(adv), .dividend_i(grow2_q), .divisor_i(shard_rows_q),
    .quot_o(sp_quo), .rem_o(sp_rem)
  );
  bctp_div #(.NW(IdxW), .DW(DimW), .QW(SpQW)) u_div_sc (
    .clk_i, .en_i(adv), .dividend_i(gcol2_q), .divisor_i(shard_cols_q),
    .quot_o(spc_quo), .rem_o(spc_rem)
  );

  // source rank and partial products after the short dividers
  logic [SpQW+GridW-1:0] spq_full;
  logic [RankW-1:0]      spq_d, srank_d;
  assign spq_full = (SpQW+GridW)'(sp_quo) * (SpQW+GridW)'(grid_cols_q);
  assign spq_d    = spq_full[RankW-1:0];
  assign srank_d  = spq_d + RankW'(spc_quo);

  // target side after the long dividers
  logic [GridW-1:0]   tprow, tpcol;
  logic [2*GridW-1:0] dstq_full;
  logic [2*DimW-1:0]  frow_full, fcol_full;
  logic [RankW-1:0]   mid_d, dst_d;
  logic               err2_d;

  assign tprow     = qr_rem[GridW-1:0];
  assign tpcol     = qc_rem[GridW-1:0];
  assign dstq_full = (2*GridW)'(tprow) * (2*GridW)'(grid_cols_q);
  assign frow_full = (2*DimW)'(qr_quo) * (2*DimW)'(tile_height_q);
  assign fcol_full = (2*DimW)'(qc_quo) * (2*DimW)'(tile_width_q);

  logic [RankW-1:0] spq_q   [StSp+1:StDv];
  logic [RankW-1:0] srank_q [StSp+1:StL];
  logic [DimW-1:0]  srow_q  [StSp+1:StL];
  logic [DimW-1:0]  scol_q  [StSp+1:StL];
  logic [StL:3]     oor_q;
  logic [RankW-1:0] mid_q, dst_q;
  logic [DimW-1:0]  frow_q, fcol_q;
  logic             err2_q;

  assign mid_d  = spq_q[StDv] + RankW'(tpcol);
  assign dst_d  = dstq_full[RankW-1:0] + RankW'(tpcol);
  assign err2_d = (mr_rem != '0) || (mc_rem != '0);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tr1_q   <= in_data_i.tile_row_index;
      tc1_q   <= in_data_i.tile_col_index;
      grow2_q <= grow_full[IdxW-1:0];
      gcol2_q <= gcol_full[IdxW-1:0];
      nr2_q   <= nr_d;
      nc2_q   <= nc_d;
      limr2_q <= limr_d;
      limc2_q <= limc_d;
      oor_q[3] <= oor_d;
      for (int k = 4; k <= StL; k++) oor_q[k] <= oor_q[k-1];
      spq_q[StSp+1]   <= spq_d;
      srank_q[StSp+1] <= srank_d;
      srow_q[StSp+1]  <= sp_rem[DimW-1:0];
      scol_q[StSp+1]  <= spc_rem[DimW-1:0];
      for (int k = StSp + 2; k <= StDv; k++) spq_q[k] <= spq_q[k-1];
      for (int k = StSp + 2; k <= StL; k++) begin
        srank_q[k] <= srank_q[k-1];
        srow_q[k]  <= srow_q[k-1];
        scol_q[k]  <= scol_q[k-1];
      end
      mid_q  <= mid_d;
      dst_q  <= dst_d;
      frow_q <= frow_full[DimW-1:0];
      fcol_q <= fcol_full[DimW-1:0];
      err2_q <= err2_d;
    end
  end

  // last stage: classify and build up to two descriptors
  logic err1, err_any, need0, need1, has_res, two_res;
  bctp_pkg::status_e   status;
  bctp_pkg::out_item_t res0, res1, first_res;

  always_comb begin
    err1 = (grid_rows_q == '0) || (grid_cols_q == '0) ||
           (tile_height_q == '0) || (tile_width_q == '0) ||
           (32'(grid_rows_q) > bctp_pkg::MAX_GRID_DIM) ||
           (32'(grid_cols_q) > bctp_pkg::MAX_GRID_DIM) ||
           (32'(shard_rows_q) > bctp_pkg::MAX_SHARD_DIM) ||
           (32'(shard_cols_q) > bctp_pkg::MAX_SHARD_DIM);
    if (err1)             status = bctp_pkg::STATUS_BAD_SIZE;
    else if (err2_q)      status = bctp_pkg::STATUS_UNALIGNED;
    else if (oor_q[StL])  status = bctp_pkg::STATUS_TILE_RANGE;
    else                  status = bctp_pkg::STATUS_OK;
    err_any = (status != bctp_pkg::STATUS_OK);

    need0 = (srank_q[StL] != mid_q) || (scol_q[StL] != fcol_q);
    need1 = (mid_q != dst_q) || (srow_q[StL] != frow_q);

    res0.status         = bctp_pkg::STATUS_OK;
    res0.phase_id       = bctp_pkg::PHASE_COL;
    res0.from_rank      = srank_q[StL];
    res0.to_rank        = mid_q;
    res0.src_row_offset = srow_q[StL];
    res0.src_col_offset = scol_q[StL];
    res0.dst_row_offset = srow_q[StL];
    res0.dst_col_offset = fcol_q;
    res0.last_of_tile   = !need1;

    res1.status         = bctp_pkg::STATUS_OK;
    res1.phase_id       = bctp_pkg::PHASE_ROW;
    res1.from_rank      = mid_q;
    res1.to_rank        = dst_q;
    res1.src_row_offset = srow_q[StL];
    res1.src_col_offset = fcol_q;
    res1.dst_row_offset = frow_q;
    res1.dst_col_offset = fcol_q;
    res1.last_of_tile   = 1'b1;

    if (err_any) begin
      first_res              = '0;
      first_res.status       = status;
      first_res.last_of_tile = 1'b1;
    end else if (need0) begin
      first_res = res0;
    end else begin
      first_res = res1;
    end
    has_res = err_any || need0 || need1;
    two_res = !err_any && need0 && need1;
  end

  // output register plus one pending second descriptor
  logic fire;
  assign fire = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else if (fire && pend_valid_q) begin
      pend_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q  <= v_q[StL] && has_res;
      pend_valid_q <= v_q[StL] && two_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && pend_valid_q) begin
      out_q <= pend_q;
    end else if (adv) begin
      out_q  <= first_res;
      pend_q <= res1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_pend_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q) else $error("pending descriptor without current one");

  a_pend_stalls_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> in_stall_o) else $error("input taken while second descriptor pending");

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != bctp_pkg::STATUS_OK) |-> out_data_o.last_of_tile)
    else $error("error result not marked last");

  a_not_last_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.last_of_tile) |-> pend_valid_q)
    else $error("non-final descriptor without a follower");

  a_second_is_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && pend_valid_q) |=> (out_valid_o && out_data_o.phase_id == bctp_pkg::PHASE_ROW))
    else $error("second descriptor is not a row move");
`endif

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the block-cyclic transfer planner core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GridW    = bctp_pkg::GridW;
  localparam int unsigned DimW     = bctp_pkg::DimW;
  localparam int unsigned IdxW     = bctp_pkg::IdxW;
  localparam int unsigned RankW    = bctp_pkg::RankW;
  localparam int unsigned CfgIdxW  = bctp_pkg::CfgIdxW;
  localparam int unsigned CfgDataW = bctp_pkg::CfgDataW;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned DrainCycles   = 40;

  class plan_scoreboard;
    logic [GridW-1:0]    grid_rows = 1, grid_cols = 1;
    logic [DimW-1:0]     tile_h = 1, tile_w = 1, shard_r = 1, shard_c = 1;
    bctp_pkg::out_item_t plan_q[$];
    int unsigned         errors, n_desc, n_err_desc, n_tiles;

    function void set_reg(bctp_pkg::reg_idx_e idx, logic [CfgDataW-1:0] val);
      case (idx)
        bctp_pkg::REG_GRID_ROWS:   grid_rows = val[GridW-1:0];
        bctp_pkg::REG_GRID_COLS:   grid_cols = val[GridW-1:0];
        bctp_pkg::REG_TILE_HEIGHT: tile_h = val;
        bctp_pkg::REG_TILE_WIDTH:  tile_w = val;
        bctp_pkg::REG_SHARD_ROWS:  shard_r = val;
        default:                   shard_c = val;
      endcase
    endfunction

    // Tile counts along each axis, 0 when the tile size is zero.
    function longint unsigned tiles_down();
      return (tile_h == 0) ? 0 : (longint'(shard_r) * grid_rows) / tile_h;
    endfunction
    function longint unsigned tiles_across();
      return (tile_w == 0) ? 0 : (longint'(shard_c) * grid_cols) / tile_w;
    endfunction

    function void add_desc(bctp_pkg::out_item_t r);
      plan_q.insert(plan_q.size(), r);
    endfunction

    function void push_error(bctp_pkg::status_e st);
      bctp_pkg::out_item_t r;
      r = '0;
      r.status = st;
      r.last_of_tile = 1'b1;
      add_desc(r);
    endfunction

    function bit fits(longint unsigned start, longint unsigned cnt, longint unsigned lim);
      return cnt > 0 && start + cnt <= lim;
    endfunction

    function void note_tile(bctp_pkg::in_item_t it);
      longint unsigned tr, tc, p, q, th, tw, lr, lc;
      longint unsigned grow, gcol, sprow, spcol, tprow, tpcol, srow, scol, frow, fcol;
      longint unsigned src_rank, mid_rank, dst_rank;
      bit need_col, need_row;
      bctp_pkg::out_item_t r;
      tr = it.tile_row_index; tc = it.tile_col_index;
      p = grid_rows; q = grid_cols; th = tile_h; tw = tile_w; lr = shard_r; lc = shard_c;
      n_tiles++;
      if (p == 0 || q == 0 || th == 0 || tw == 0 ||
          p > bctp_pkg::MAX_GRID_DIM || q > bctp_pkg::MAX_GRID_DIM ||
          lr > bctp_pkg::MAX_SHARD_DIM || lc > bctp_pkg::MAX_SHARD_DIM) begin
        push_error(bctp_pkg::STATUS_BAD_SIZE);
        return;
      end
      if (lr % th != 0 || lc % tw != 0) begin
        push_error(bctp_pkg::STATUS_UNALIGNED);
        return;
      end
      if (tr >= (lr * p) / th || tc >= (lc * q) / tw) begin
        push_error(bctp_pkg::STATUS_TILE_RANGE);
        return;
      end
      grow = tr * th;  gcol = tc * tw;
      sprow = grow / lr;  spcol = gcol / lc;
      tprow = tr % p;  tpcol = tc % q;
      srow = grow - sprow * lr;  scol = gcol - spcol * lc;
      frow = (tr / p) * th;  fcol = (tc / q) * tw;
      if (!fits(srow, th, lr) || !fits(scol, tw, lc) || !fits(fcol, tw, lc) ||
          !fits(frow, th, lr)) begin
        push_error(bctp_pkg::STATUS_RECT_OOB);
        return;
      end
      src_rank = sprow * q + spcol;
      mid_rank = sprow * q + tpcol;
      dst_rank = tprow * q + tpcol;
      need_col = (src_rank != mid_rank) || (scol != fcol);
      need_row = (mid_rank != dst_rank) || (srow != frow);
      if (need_col) begin
        r.status = bctp_pkg::STATUS_OK;  r.phase_id = bctp_pkg::PHASE_COL;
        r.from_rank = src_rank[RankW-1:0];  r.to_rank = mid_rank[RankW-1:0];
        r.src_row_offset = srow[DimW-1:0];  r.src_col_offset = scol[DimW-1:0];
        r.dst_row_offset = srow[DimW-1:0];  r.dst_col_offset = fcol[DimW-1:0];
        r.last_of_tile = !need_row;
        add_desc(r);
      end
      if (need_row) begin
        r.status = bctp_pkg::STATUS_OK;  r.phase_id = bctp_pkg::PHASE_ROW;
        r.from_rank = mid_rank[RankW-1:0];  r.to_rank = dst_rank[RankW-1:0];
        r.src_row_offset = srow[DimW-1:0];  r.src_col_offset = fcol[DimW-1:0];
        r.dst_row_offset = frow[DimW-1:0];  r.dst_col_offset = fcol[DimW-1:0];
        r.last_of_tile = 1'b1;
        add_desc(r);
      end
    endfunction

    function void cmp_field(string name, longint unsigned e, longint unsigned a);
      if (e != a) begin
        $display("%0t: MISMATCH %s expected %0d actual %0d", $realtime, name, e, a);
        errors++;
      end
    endfunction

    function void check_desc(bctp_pkg::out_item_t got);
      bctp_pkg::out_item_t e;
      if (plan_q.size() == 0) begin
        $display("%0t: MISMATCH unexpected descriptor expected none actual %h",
                 $realtime, got);
        errors++;
        return;
      end
      e = plan_q.pop_front();
      n_desc++;
      if (got.status != bctp_pkg::STATUS_OK) n_err_desc++;
      cmp_field("status", e.status, got.status);
      cmp_field("phase_id", e.phase_id, got.phase_id);
      cmp_field("from_rank", e.from_rank, got.from_rank);
      cmp_field("to_rank", e.to_rank, got.to_rank);
      cmp_field("src_row_offset", e.src_row_offset, got.src_row_offset);
      cmp_field("src_col_offset", e.src_col_offset, got.src_col_offset);
      cmp_field("dst_row_offset", e.dst_row_offset, got.dst_row_offset);
      cmp_field("dst_col_offset", e.dst_col_offset, got.dst_col_offset);
      cmp_field("last_of_tile", e.last_of_tile, got.last_of_tile);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  bctp_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  bctp_pkg::out_item_t out_data;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  bit                  idle_on = 1'b1;
  int unsigned         quiet_cycles = 0;
  plan_scoreboard      sb = new();

  block_cyclic_transfer_planner_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 34);
  end

  // Monitors and watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_tile(in_data);
      if (out_valid && !out_stall) sb.check_desc(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
        $display("tb_top: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_tile(logic [IdxW-1:0] tr, logic [IdxW-1:0] tc);
    if (idle_on && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 34);
    end
    in_valid <= 1'b1;
    in_data.tile_row_index <= tr;
    in_data.tile_col_index <= tc;
    do @(posedge clk); while (in_stall);
  endtask

  // Registers change only once the pipeline is empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.plan_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(bctp_pkg::reg_idx_e idx, logic [CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_layout(int p, int q, int th, int tw, int lr, int lc);
    wait_idle();
    write_reg(bctp_pkg::REG_GRID_ROWS, CfgDataW'(p));
    write_reg(bctp_pkg::REG_GRID_COLS, CfgDataW'(q));
    write_reg(bctp_pkg::REG_TILE_HEIGHT, CfgDataW'(th));
    write_reg(bctp_pkg::REG_TILE_WIDTH, CfgDataW'(tw));
    write_reg(bctp_pkg::REG_SHARD_ROWS, CfgDataW'(lr));
    write_reg(bctp_pkg::REG_SHARD_COLS, CfgDataW'(lc));
  endtask

  // Mostly in-range tiles, some anywhere in the 20-bit field.
  task automatic random_tiles(int n);
    longint unsigned nr, nc;
    logic [IdxW-1:0] tr, tc;
    nr = sb.tiles_down();
    nc = sb.tiles_across();
    repeat (n) begin
      tr = IdxW'($urandom);
      tc = IdxW'($urandom);
      if (nr > 0 && $urandom_range(99) < 85) tr = IdxW'($urandom_range(32'(nr - 1)));
      if (nc > 0 && $urandom_range(99) < 85) tc = IdxW'($urandom_range(32'(nc - 1)));
      send_tile(tr, tc);
    end
  endtask

  initial begin
    int th, tw;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset layout, a typical layout, and each error status the core produces.
    send_tile(0, 0);
    send_tile(1, 0);
    send_tile('1, '1);
    set_layout(4, 4, 2, 2, 8, 8);
    send_tile(0, 0);
    send_tile(5, 3);
    send_tile(15, 15);
    send_tile(3, 12);
    send_tile(16, 0);
    send_tile(0, 16);
    set_layout(16, 16, 1, 1, 65535, 65535);
    send_tile(1048559, 1048559);
    send_tile(65535, 1);
    send_tile(1048560, 0);
    set_layout(31, 1, 1, 1, 4, 4);
    send_tile(0, 0);
    set_layout(0, 4, 1, 1, 4, 4);
    send_tile(0, 0);
    set_layout(2, 2, 0, 65535, 4, 65535);
    send_tile(0, 0);
    set_layout(2, 2, 2, 3, 5, 6);
    send_tile(1, 1);
    set_layout(2, 2, 2, 2, 0, 4);
    send_tile(0, 0);
    set_layout(3, 5, 4, 8, 16, 40);
    send_tile(11, 24);

    // Random layouts; the second stretch runs without idling on either side.
    for (int ph = 0; ph < 9; ph++) begin
      idle_on = (ph != 1);
      th = $urandom_range(1, 64);
      tw = $urandom_range(1, 64);
      case ($urandom_range(9))
        0:       set_layout($urandom_range(31), $urandom_range(31), $urandom_range(3),
                            $urandom_range(3), $urandom_range(9), $urandom_range(9));
        1:       set_layout(16, 16, th, tw, th * $urandom_range(1, 65535 / th),
                            tw * $urandom_range(1, 65535 / tw));
        default: set_layout($urandom_range(1, 16), $urandom_range(1, 16), th, tw,
                            th * $urandom_range(1, 8), tw * $urandom_range(1, 8));
      endcase
      random_tiles(70);
    end

    wait_idle();
    $display("covered %0d tiles over several layouts, %0d descriptors checked (%0d errors)",
             sb.n_tiles, sb.n_desc, sb.n_err_desc);
    if (sb.errors == 0 && sb.plan_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("%0d mismatches, %0d descriptors never seen", sb.errors, sb.plan_q.size());
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule
